FILE: sv/priority_round_robin_scheduler_macros.svh
// ----------------------------------------------------------------------------
// priority round-robin scheduler assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef PRIORITY_ROUND_ROBIN_SCHEDULER_MACROS_SVH
`define PRIORITY_ROUND_ROBIN_SCHEDULER_MACROS_SVH

// same-cycle implication
`define PRS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define PRS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/prs_pkg.sv
// ----------------------------------------------------------------------------
// prs_pkg
// types and constants of the priority round-robin scheduler
// ----------------------------------------------------------------------------
package prs_pkg;

  // command codes
  localparam logic [2:0] CMD_CREATE    = 3'd0;
  localparam logic [2:0] CMD_ACTIVATE  = 3'd1;
  localparam logic [2:0] CMD_TERMINATE = 3'd2;
  localparam logic [2:0] CMD_WAIT      = 3'd3;
  localparam logic [2:0] CMD_TICK      = 3'd4;
  localparam logic [2:0] CMD_START     = 3'd5;

  // task modes
  localparam logic [1:0] MODE_SUSP  = 2'd0;
  localparam logic [1:0] MODE_WAIT  = 2'd1;
  localparam logic [1:0] MODE_READY = 2'd2;
  localparam logic [1:0] MODE_RUN   = 2'd3;

  // status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOSLOT  = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;

  localparam logic [7:0] IDLE_PRIO  = 8'd255;
  localparam logic [8:0] BEST_INIT  = 9'h1FF;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_RMW, S_TICK, S_RS1, S_RS2,
    S_SEL_RD, S_SEL_CUR, S_SEL_NXT, S_SEL_WB, S_DONE
  } state_t;

  // per-slot flags from the shared slot unit
  typedef struct packed {
    logic elig;
    logic lt_best;
    logic eq_best;
    logic tick_hit;
    logic wake;
  } alu_res_t;

endpackage

FILE: sv/priority_round_robin_scheduler.sv
// Throughput: one command at a time; the table scans go one slot per cycle
//   through the single read port of the task table.
// Reset: synchronous active-low; idle task in slot 0, queue empty, not running.
// ----------------------------------------------------------------------------
// priority_round_robin_scheduler
// task scheduler with fixed priorities and round robin within a priority
// ----------------------------------------------------------------------------
`include "priority_round_robin_scheduler_macros.svh"

module priority_round_robin_scheduler #(
  parameter int MAX_TASKS  = 16,
  parameter int WAIT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // command[2:0], task_slot[6:3], task_priority[14:7], wait_ticks[30:15]
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // running_task[3:0], switch_request[4], ready_count[9:5], status[11:10]
  output logic [15:0] out_tdata
);
  import prs_pkg::*;

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  state_t state_r, state_nxt;

  logic [2:0]            cmd_r, cmd_nxt;
  logic [3:0]            slot_r, slot_nxt;
  logic [7:0]            prio_r, prio_nxt;
  logic [15:0]           ticks_r, ticks_nxt;
  logic                  running_r, running_nxt;
  logic [IW-1:0]         cur_r, cur_nxt;
  logic                  sw_r, sw_nxt;
  logic [1:0]            status_r, status_nxt;
  logic                  woke_r, woke_nxt;
  logic                  sel_after_r, sel_after_nxt;
  logic [IW:0]           scan_r, scan_nxt;
  logic [8:0]            best_r, best_nxt;
  logic [IW-1:0]         nxt_r, nxt_nxt;
  logic [IW-1:0]         cs_addr_r, cs_addr_nxt;
  logic [7:0]            cs_prio_r, cs_prio_nxt;
  logic [1:0]            cs_mode_r, cs_mode_nxt;
  logic                  cs_present_r, cs_present_nxt;
  logic                  cs_wen_r, cs_wen_nxt;
  logic [WAIT_WIDTH-1:0] cs_cnt_r, cs_cnt_nxt;
  logic                  out_v_r, out_v_nxt;
  logic [15:0]           out_d_r, out_d_nxt;

  logic                  in_acc;
  logic                  slot_ok;
  logic [IW+3:0]         slot_ext;
  logic [IW-1:0]         slot_a;
  logic [WAIT_WIDTH+15:0] ticks_ext;
  logic [IW+3:0]         cur_ext;
  logic [IW+5:0]         fill_ext;
  logic                  proc, last, out_free, requeue;
  logic [IW:0]           scan_m1;
  logic [IW-1:0]         p_addr, scan_addr;

  logic [IW-1:0]         t_rd_addr, t_wr_addr;
  logic [7:0]            t_rd_prio, t_wr_prio;
  logic [1:0]            t_rd_mode, t_wr_mode;
  logic                  t_rd_present, t_wr_present, t_rd_wen, t_wr_wen, t_wr_en;
  logic [WAIT_WIDTH-1:0] t_rd_cnt, t_wr_cnt, cnt_dec;
  logic                  q_clear, q_push, q_pop;
  logic [IW-1:0]         q_push_data, q_head;
  logic [IW:0]           q_fill;
  alu_res_t              alu;

  prs_task_tbl #(.MAX_TASKS(MAX_TASKS), .WAIT_WIDTH(WAIT_WIDTH), .IW(IW)) u_tbl (
    .clk(clk), .rst_n(rst_n),
    .rd_addr(t_rd_addr), .rd_prio(t_rd_prio), .rd_mode(t_rd_mode),
    .rd_present(t_rd_present), .rd_wen(t_rd_wen), .rd_cnt(t_rd_cnt),
    .wr_en(t_wr_en), .wr_addr(t_wr_addr), .wr_prio(t_wr_prio), .wr_mode(t_wr_mode),
    .wr_present(t_wr_present), .wr_wen(t_wr_wen), .wr_cnt(t_wr_cnt)
  );

  prs_ready_q #(.MAX_TASKS(MAX_TASKS), .IW(IW)) u_q (
    .clk(clk), .rst_n(rst_n), .clear(q_clear), .push(q_push),
    .push_data(q_push_data), .pop(q_pop), .fill(q_fill), .head_data(q_head)
  );

  prs_slot_alu #(.WAIT_WIDTH(WAIT_WIDTH)) u_alu (
    .prio(t_rd_prio), .mode(t_rd_mode), .present(t_rd_present), .wen(t_rd_wen),
    .cnt(t_rd_cnt), .best(best_r), .res(alu), .cnt_dec(cnt_dec)
  );

  // handshake and helpers
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_free   = !out_v_r || out_tready;

  assign slot_ext  = {{IW{1'b0}}, slot_r};
  assign slot_a    = slot_ext[IW-1:0];
  assign slot_ok   = (32'(slot_r) < 32'(MAX_TASKS));
  assign ticks_ext = {{WAIT_WIDTH{1'b0}}, ticks_r};
  assign cur_ext   = {4'b0, cur_r};

  // ready count widened to the five-bit field
  assign fill_ext  = {5'b0, q_fill};

  // table scan: read slot scan_r, process slot scan_r-1
  assign proc      = (scan_r != '0);
  assign last      = (scan_r == (IW+1)'(MAX_TASKS));
  assign scan_m1   = scan_r - 1'b1;
  assign p_addr    = scan_m1[IW-1:0];
  assign scan_addr = last ? '0 : scan_r[IW-1:0];
  assign requeue   = (cs_prio_r == t_rd_prio) &&
                     ((nxt_r == cs_addr_r) || (cs_mode_r != MODE_SUSP));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_DEC;
      S_DEC: begin
        unique case (cmd_r)
          CMD_ACTIVATE, CMD_TERMINATE, CMD_WAIT: state_nxt = slot_ok ? S_RMW : S_DONE;
          CMD_TICK:  state_nxt = running_r ? S_TICK : S_DONE;
          CMD_START: state_nxt = S_RMW;
          default:   state_nxt = S_DONE;
        endcase
      end
      S_RMW: begin
        state_nxt = (cmd_r == CMD_START || t_rd_present) ? S_RS1 : S_DONE;
      end
      S_TICK: if (last) state_nxt = (woke_r || alu.wake) ? S_RS1 : S_SEL_RD;
      S_RS1:  if (last) state_nxt = S_RS2;
      S_RS2:  if (last) state_nxt = sel_after_r ? S_SEL_RD : S_DONE;
      S_SEL_RD:  state_nxt = S_SEL_CUR;
      S_SEL_CUR: state_nxt = (q_fill == '0) ? S_DONE : S_SEL_NXT;
      S_SEL_NXT: state_nxt = (requeue && nxt_r != cs_addr_r) ? S_SEL_WB : S_DONE;
      S_SEL_WB:  state_nxt = S_DONE;
      S_DONE:    if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cmd_nxt        = cmd_r;
    slot_nxt       = slot_r;
    prio_nxt       = prio_r;
    ticks_nxt      = ticks_r;
    running_nxt    = running_r;
    cur_nxt        = cur_r;
    sw_nxt         = sw_r;
    status_nxt     = status_r;
    woke_nxt       = woke_r;
    sel_after_nxt  = sel_after_r;
    best_nxt       = best_r;
    nxt_nxt        = nxt_r;
    cs_addr_nxt    = cs_addr_r;
    cs_prio_nxt    = cs_prio_r;
    cs_mode_nxt    = cs_mode_r;
    cs_present_nxt = cs_present_r;
    cs_wen_nxt     = cs_wen_r;
    cs_cnt_nxt     = cs_cnt_r;
    out_d_nxt      = out_d_r;
    out_v_nxt      = out_tready ? 1'b0 : out_v_r;
    scan_nxt       = '0;
    t_rd_addr      = '0;
    t_wr_en        = 1'b0;
    t_wr_addr      = '0;
    t_wr_prio      = t_rd_prio;
    t_wr_mode      = t_rd_mode;
    t_wr_present   = t_rd_present;
    t_wr_wen       = t_rd_wen;
    t_wr_cnt       = t_rd_cnt;
    q_clear        = 1'b0;
    q_push         = 1'b0;
    q_push_data    = '0;
    q_pop          = 1'b0;

    unique case (state_r)
      // capture the item
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt    = in_tdata[2:0];
          slot_nxt   = in_tdata[6:3];
          prio_nxt   = in_tdata[14:7];
          ticks_nxt  = in_tdata[30:15];
          sw_nxt     = 1'b0;
          status_nxt = STAT_OK;
          woke_nxt   = 1'b0;
        end
      end
      // decode; create writes the entry at once
      S_DEC: begin
        unique case (cmd_r)
          CMD_CREATE: begin
            if (!slot_ok || slot_r == 4'd0) begin
              status_nxt = STAT_FULL;
            end else begin
              t_wr_en      = 1'b1;
              t_wr_addr    = slot_a;
              t_wr_prio    = prio_r;
              t_wr_mode    = MODE_SUSP;
              t_wr_present = 1'b1;
              t_wr_wen     = 1'b0;
              t_wr_cnt     = '0;
            end
          end
          CMD_ACTIVATE, CMD_TERMINATE, CMD_WAIT: begin
            if (!slot_ok) status_nxt = STAT_NOSLOT;
            t_rd_addr = slot_ok ? slot_a : '0;
          end
          CMD_START: begin
            running_nxt = 1'b1;
            cur_nxt     = '0;
          end
          default: ;
        endcase
      end
      // read-modify-write of the addressed slot
      S_RMW: begin
        if (cmd_r == CMD_START) begin
          t_wr_en       = 1'b1;
          t_wr_mode     = MODE_WAIT;
          sel_after_nxt = 1'b0;
        end else if (!t_rd_present) begin
          status_nxt = STAT_NOSLOT;
        end else begin
          t_wr_en   = 1'b1;
          t_wr_addr = slot_a;
          if (cmd_r == CMD_ACTIVATE) begin
            t_wr_mode = MODE_WAIT;
          end else begin
            t_wr_mode = MODE_SUSP;
          end
          if (cmd_r == CMD_WAIT) begin
            t_wr_wen = 1'b1;
            t_wr_cnt = ticks_ext[WAIT_WIDTH-1:0];
          end
          sel_after_nxt = running_r && (cur_r != '0);
        end
      end
      // wait countdown pass
      S_TICK: begin
        t_rd_addr = scan_addr;
        scan_nxt  = last ? '0 : scan_r + 1'b1;
        if (proc && alu.tick_hit) begin
          t_wr_en   = 1'b1;
          t_wr_addr = p_addr;
          t_wr_cnt  = cnt_dec;
          if (alu.wake) begin
            t_wr_wen  = 1'b0;
            t_wr_mode = MODE_WAIT;
            woke_nxt  = 1'b1;
          end
        end
        sel_after_nxt = 1'b1;
      end
      // find the best priority among eligible tasks
      S_RS1: begin
        t_rd_addr = scan_addr;
        scan_nxt  = last ? '0 : scan_r + 1'b1;
        if (!proc) begin
          best_nxt = BEST_INIT;
          q_clear  = 1'b1;
        end else if (alu.elig && alu.lt_best) begin
          best_nxt = {1'b0, t_rd_prio};
        end
      end
      // enqueue every eligible task at the best priority
      S_RS2: begin
        t_rd_addr = scan_addr;
        scan_nxt  = last ? '0 : scan_r + 1'b1;
        if (proc && alu.elig && alu.eq_best) begin
          q_push      = 1'b1;
          q_push_data = p_addr;
          t_wr_en     = 1'b1;
          t_wr_addr   = p_addr;
          t_wr_mode   = MODE_READY;
        end
      end
      S_SEL_RD: begin
        t_rd_addr = cur_r;
      end
      // current task known; keep it running or pop the next one
      S_SEL_CUR: begin
        cs_addr_nxt    = cur_r;
        cs_prio_nxt    = t_rd_prio;
        cs_mode_nxt    = t_rd_mode;
        cs_present_nxt = t_rd_present;
        cs_wen_nxt     = t_rd_wen;
        cs_cnt_nxt     = t_rd_cnt;
        if (q_fill == '0) begin
          if (t_rd_mode != MODE_SUSP) begin
            t_wr_en     = 1'b1;
            t_wr_addr   = cur_r;
            t_wr_mode   = MODE_RUN;
            q_push      = 1'b1;
            q_push_data = cur_r;
            sw_nxt      = 1'b1;
          end
        end else begin
          nxt_nxt   = q_head;
          q_pop     = 1'b1;
          t_rd_addr = q_head;
        end
      end
      // next task runs; an equal-priority current task goes back in line
      S_SEL_NXT: begin
        t_wr_en   = 1'b1;
        t_wr_addr = nxt_r;
        t_wr_mode = (requeue && nxt_r == cs_addr_r) ? MODE_READY : MODE_RUN;
        if (requeue) begin
          q_push      = 1'b1;
          q_push_data = cs_addr_r;
        end
        cur_nxt = nxt_r;
        sw_nxt  = 1'b1;
      end
      S_SEL_WB: begin
        t_wr_en      = 1'b1;
        t_wr_addr    = cs_addr_r;
        t_wr_prio    = cs_prio_r;
        t_wr_mode    = MODE_READY;
        t_wr_present = cs_present_r;
        t_wr_wen     = cs_wen_r;
        t_wr_cnt     = cs_cnt_r;
      end
      // load the result register
      S_DONE: begin
        if (out_free) begin
          out_v_nxt = 1'b1;
          out_d_nxt = {4'b0, status_r, fill_ext[4:0], sw_r, cur_ext[3:0]};
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      running_r <= 1'b0;
      cur_r     <= '0;
      out_v_r   <= 1'b0;
      woke_r    <= 1'b0;
      scan_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      running_r <= running_nxt;
      cur_r     <= cur_nxt;
      out_v_r   <= out_v_nxt;
      woke_r    <= woke_nxt;
      scan_r    <= scan_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    slot_r       <= slot_nxt;
    prio_r       <= prio_nxt;
    ticks_r      <= ticks_nxt;
    sw_r         <= sw_nxt;
    status_r     <= status_nxt;
    sel_after_r  <= sel_after_nxt;
    best_r       <= best_nxt;
    nxt_r        <= nxt_nxt;
    cs_addr_r    <= cs_addr_nxt;
    cs_prio_r    <= cs_prio_nxt;
    cs_mode_r    <= cs_mode_nxt;
    cs_present_r <= cs_present_nxt;
    cs_wen_r     <= cs_wen_nxt;
    cs_cnt_r     <= cs_cnt_nxt;
    out_d_r      <= out_d_nxt;
  end

  // checks
  `PRS_ASSERT_IMP(a_fill_bound, 1'b1, q_fill <= (IW+1)'(MAX_TASKS))
  `PRS_ASSERT_IMP(a_cur_range, 1'b1, 32'(cur_r) < 32'(MAX_TASKS))
  `PRS_ASSERT_NXT(a_accept_dec, in_tvalid && in_tready, state_r == S_DEC && !in_tready)

endmodule

FILE: sv/prs_task_tbl.sv
// ----------------------------------------------------------------------------
// prs_task_tbl
// task table memory, one write and one registered read port, with per-entry
// valid bits so unwritten entries read as their reset value
// ----------------------------------------------------------------------------
module prs_task_tbl #(
  parameter int MAX_TASKS  = 16,
  parameter int WAIT_WIDTH = 16,
  parameter int IW         = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IW-1:0]         rd_addr,
  output logic [7:0]            rd_prio,
  output logic [1:0]            rd_mode,
  output logic                  rd_present,
  output logic                  rd_wen,
  output logic [WAIT_WIDTH-1:0] rd_cnt,
  input  logic                  wr_en,
  input  logic [IW-1:0]         wr_addr,
  input  logic [7:0]            wr_prio,
  input  logic [1:0]            wr_mode,
  input  logic                  wr_present,
  input  logic                  wr_wen,
  input  logic [WAIT_WIDTH-1:0] wr_cnt
);
  import prs_pkg::*;

  localparam int DW = WAIT_WIDTH + 12;

  logic [DW-1:0]        mem [MAX_TASKS];
  logic [MAX_TASKS-1:0] vld_r;
  logic [DW-1:0]        word_r;
  logic                 hit_r;
  logic                 zero_r;

  // entry storage and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_cnt, wr_wen, wr_present, wr_mode, wr_prio};
    end
    word_r <= mem[rd_addr];
    hit_r  <= vld_r[rd_addr];
    zero_r <= (rd_addr == '0);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // unwritten entries: idle task in slot 0, empty elsewhere
  always_comb begin
    if (hit_r) begin
      rd_prio    = word_r[7:0];
      rd_mode    = word_r[9:8];
      rd_present = word_r[10];
      rd_wen     = word_r[11];
      rd_cnt     = word_r[DW-1:12];
    end else begin
      rd_prio    = zero_r ? IDLE_PRIO : 8'd0;
      rd_mode    = MODE_SUSP;
      rd_present = zero_r;
      rd_wen     = 1'b0;
      rd_cnt     = '0;
    end
  end

endmodule

FILE: sv/prs_ready_q.sv
// ----------------------------------------------------------------------------
// prs_ready_q
// ready queue: circular memory with head and fill, head entry read registered
// ----------------------------------------------------------------------------
module prs_ready_q #(
  parameter int MAX_TASKS = 16,
  parameter int IW        = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clear,
  input  logic          push,
  input  logic [IW-1:0] push_data,
  input  logic          pop,
  output logic [IW:0]   fill,
  output logic [IW-1:0] head_data
);
  import prs_pkg::*;

  logic [IW-1:0] mem [MAX_TASKS];
  logic [IW-1:0] head_r, head_nxt;
  logic [IW:0]   fill_r, fill_nxt;
  logic [IW:0]   wsum;
  logic [IW-1:0] waddr;
  logic          do_push;

  // tail address, wrapped once
  assign wsum    = {1'b0, head_r} + fill_r;
  assign waddr   = (wsum >= (IW+1)'(MAX_TASKS)) ?
                   IW'(wsum - (IW+1)'(MAX_TASKS)) : wsum[IW-1:0];
  assign do_push = push && !clear && (fill_r < (IW+1)'(MAX_TASKS));

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[waddr] <= push_data;
    end
    head_data <= mem[head_r];
  end

  // pointer update
  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    priority if (clear) begin
      head_nxt = '0;
      fill_nxt = '0;
    end else if (do_push) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && fill_r != '0) begin
      head_nxt = (head_r == IW'(MAX_TASKS - 1)) ? '0 : head_r + 1'b1;
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  assign fill = fill_r;

endmodule

FILE: sv/prs_slot_alu.sv
// ----------------------------------------------------------------------------
// prs_slot_alu
// shared per-slot unit: eligibility, priority compare and wait countdown
// ----------------------------------------------------------------------------
module prs_slot_alu #(
  parameter int WAIT_WIDTH = 16
) (
  input  logic [7:0]            prio,
  input  logic [1:0]            mode,
  input  logic                  present,
  input  logic                  wen,
  input  logic [WAIT_WIDTH-1:0] cnt,
  input  logic [8:0]            best,
  output prs_pkg::alu_res_t     res,
  output logic [WAIT_WIDTH-1:0] cnt_dec
);
  import prs_pkg::*;

  // countdown wraps within the counter width
  assign cnt_dec      = cnt - 1'b1;
  assign res.elig     = present && (mode != MODE_SUSP);
  assign res.lt_best  = ({1'b0, prio} < best);
  assign res.eq_best  = ({1'b0, prio} == best);
  assign res.tick_hit = present && (mode == MODE_SUSP) && wen;
  assign res.wake     = res.tick_hit && (cnt_dec == WAIT_WIDTH'(1));

endmodule

FILE: dv/priority_round_robin_scheduler_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_round_robin_scheduler_test
// drives scheduler commands on the input stream, predicts each status item
// with a local task table model and compares every output field in order
// ----------------------------------------------------------------------------
module priority_round_robin_scheduler_test;
  import prs_pkg::*;

  localparam int NT = 16;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] ready_count;
    logic       switch_request;
    logic [3:0] running_task;
  } sched_status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  priority_round_robin_scheduler DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // scheduler model state
  logic [7:0]  m_prio [NT];
  logic [1:0]  m_mode [NT];
  logic        m_present [NT];
  logic        m_wait_en [NT];
  logic [15:0] m_wait_cnt [NT];
  logic [3:0]  m_fifo [NT];
  logic [3:0]  m_head;
  logic [4:0]  m_fill;
  logic [3:0]  m_cur;
  logic        m_running;

  sched_status_t status_queue [$];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  longint cycles = 0;

  task automatic model_reset();
    for (int s = 0; s < NT; s++) begin
      m_prio[s] = 8'd0; m_mode[s] = MODE_SUSP; m_present[s] = 1'b0;
      m_wait_en[s] = 1'b0; m_wait_cnt[s] = '0; m_fifo[s] = '0;
    end
    m_prio[0] = IDLE_PRIO;
    m_present[0] = 1'b1;
    m_head = '0; m_fill = '0; m_cur = '0; m_running = 1'b0;
  endtask

  function automatic void ready_push(input logic [3:0] s);
    if (m_fill < NT) begin
      m_fifo[4'(m_head + m_fill[3:0])] = s;
      m_fill++;
    end
  endfunction

  // refill the ready queue with the most urgent eligible tasks
  function automatic void refill_ready();
    int best;
    best = 1000;
    m_head = '0; m_fill = '0;
    for (int s = 0; s < NT; s++)
      if (m_present[s] && m_mode[s] != MODE_SUSP && m_prio[s] < best) best = m_prio[s];
    for (int s = 0; s < NT; s++)
      if (m_present[s] && m_mode[s] != MODE_SUSP && m_prio[s] == best) begin
        ready_push(4'(s));
        m_mode[s] = MODE_READY;
      end
  endfunction

  // round robin pick, switch is completed immediately
  function automatic void pick_next(output logic sw);
    logic [3:0] nxt;
    sw = 1'b0;
    if (m_mode[m_cur] != MODE_SUSP && m_fill == 0) begin
      m_mode[m_cur] = MODE_RUN;
      ready_push(m_cur);
      sw = 1'b1;
    end else if (m_fill > 0) begin
      nxt = m_fifo[m_head];
      m_head = m_head + 4'd1;
      m_fill--;
      m_mode[nxt] = MODE_RUN;
      if (m_prio[m_cur] == m_prio[nxt] && m_mode[m_cur] != MODE_SUSP) begin
        ready_push(m_cur);
        m_mode[m_cur] = MODE_READY;
      end
      m_cur = nxt;
      sw = 1'b1;
    end
  endfunction

  function automatic sched_status_t predict_status(input logic [31:0] d);
    logic [2:0] cmd;
    logic [3:0] slot;
    logic [15:0] ticks;
    logic sw, woke;
    logic [1:0] st;
    sched_status_t r;
    cmd = d[2:0]; slot = d[6:3]; ticks = d[30:15];
    sw = 1'b0; st = STAT_OK;
    case (cmd)
      CMD_CREATE: begin
        if (slot == 0) st = STAT_FULL;
        else begin
          m_present[slot] = 1'b1; m_prio[slot] = d[14:7]; m_mode[slot] = MODE_SUSP;
          m_wait_en[slot] = 1'b0; m_wait_cnt[slot] = '0;
        end
      end
      CMD_ACTIVATE, CMD_TERMINATE, CMD_WAIT: begin
        if (!m_present[slot]) st = STAT_NOSLOT;
        else begin
          if (cmd == CMD_ACTIVATE) m_mode[slot] = MODE_WAIT;
          else begin
            if (cmd == CMD_WAIT) begin
              m_wait_en[slot] = 1'b1; m_wait_cnt[slot] = ticks;
            end
            m_mode[slot] = MODE_SUSP;
          end
          refill_ready();
          if (m_running && m_cur != 0) pick_next(sw);
        end
      end
      CMD_TICK: begin
        if (m_running) begin
          woke = 1'b0;
          for (int s = 0; s < NT; s++)
            if (m_present[s] && m_mode[s] == MODE_SUSP && m_wait_en[s]) begin
              m_wait_cnt[s] = m_wait_cnt[s] - 16'd1;
              if (m_wait_cnt[s] == 16'd1) begin
                m_wait_en[s] = 1'b0; m_mode[s] = MODE_WAIT; woke = 1'b1;
              end
            end
          if (woke) refill_ready();
          pick_next(sw);
        end
      end
      CMD_START: begin
        m_running = 1'b1; m_cur = '0; m_mode[0] = MODE_WAIT;
        refill_ready();
      end
      default: ;
    endcase
    r.running_task = m_cur; r.switch_request = sw;
    r.ready_count = m_fill; r.status = st;
    return r;
  endfunction

  function automatic logic [31:0] pack_cmd(input logic [2:0] c, input logic [3:0] s,
                                           input logic [7:0] p, input logic [15:0] w);
    return {1'b0, w, p, s, c};
  endfunction

  // send one command, with random idle cycles before it
  task automatic send_cmd(input logic [31:0] d);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_tdata = d;
    in_tvalid = 1'b1;
    status_queue.push_back(predict_status(d));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic drain();
    while (status_queue.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (rst_n) out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // compare every output item against the oldest prediction
  always @(posedge clk) begin
    sched_status_t got, exp_st;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[11:0];
      if (status_queue.size() == 0) begin
        $display("%0t unexpected item actual %h", $time, got);
        errors++;
      end else begin
        exp_st = status_queue.pop_front();
        checked++;
        if (got.running_task !== exp_st.running_task)
          begin $display("%0t running_task expected %0d actual %0d", $time,
                         exp_st.running_task, got.running_task); errors++; end
        if (got.switch_request !== exp_st.switch_request)
          begin $display("%0t switch_request expected %0d actual %0d", $time,
                         exp_st.switch_request, got.switch_request); errors++; end
        if (got.ready_count !== exp_st.ready_count)
          begin $display("%0t ready_count expected %0d actual %0d", $time,
                         exp_st.ready_count, got.ready_count); errors++; end
        if (got.status !== exp_st.status)
          begin $display("%0t status expected %0d actual %0d", $time,
                         exp_st.status, got.status); errors++; end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("[priority_round_robin_scheduler] ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    send_cmd(pack_cmd(CMD_TICK, 4'd0, 8'd0, 16'd0));      // tick while stopped
    send_cmd(pack_cmd(CMD_ACTIVATE, 4'd5, 8'd0, 16'd0));  // slot not created
    send_cmd(pack_cmd(CMD_CREATE, 4'd0, 8'd1, 16'd0));    // create on idle slot, refused
    send_cmd(pack_cmd(CMD_CREATE, 4'd1, 8'd0, 16'd0));
    send_cmd(pack_cmd(CMD_CREATE, 4'd15, 8'd255, 16'hFFFF));
    send_cmd(pack_cmd(CMD_CREATE, 4'd2, 8'd0, 16'd0));
    send_cmd(pack_cmd(CMD_START, 4'd0, 8'd0, 16'd0));
    send_cmd(pack_cmd(CMD_ACTIVATE, 4'd1, 8'd0, 16'd0));
    send_cmd(pack_cmd(CMD_ACTIVATE, 4'd2, 8'd0, 16'd0));
    send_cmd(pack_cmd(CMD_TICK, 4'd0, 8'd0, 16'd0));
    send_cmd(pack_cmd(CMD_TICK, 4'd0, 8'd0, 16'd0));
    send_cmd(pack_cmd(CMD_WAIT, 4'd1, 8'd0, 16'd3));
    send_cmd(pack_cmd(CMD_TICK, 4'd0, 8'd0, 16'd0));
    send_cmd(pack_cmd(CMD_TICK, 4'd0, 8'd0, 16'd0));
    send_cmd(pack_cmd(CMD_WAIT, 4'd2, 8'd0, 16'd0));      // wrapping countdown
    send_cmd(pack_cmd(CMD_TERMINATE, 4'd1, 8'd0, 16'd0));
    send_cmd(pack_cmd(CMD_TERMINATE, 4'd0, 8'd0, 16'd0)); // nothing to run
    send_cmd(pack_cmd(CMD_TICK, 4'd0, 8'd0, 16'd0));
    send_cmd(pack_cmd(CMD_ACTIVATE, 4'd15, 8'd0, 16'd0));
    send_cmd(pack_cmd(CMD_START, 4'd0, 8'd0, 16'd0));     // start while running
    send_cmd(pack_cmd(3'd6, 4'd3, 8'd7, 16'd9));
    send_cmd(pack_cmd(3'd7, 4'hF, 8'hFF, 16'hFFFF));
    drain();
  endtask

  // mostly live scheduling with small wait counts, some raw noise
  task automatic test_random(input int n);
    logic [2:0] c;
    logic [15:0] w;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0, 1:    c = CMD_CREATE;
        2, 3:    c = CMD_ACTIVATE;
        4:       c = CMD_TERMINATE;
        5:       c = CMD_WAIT;
        6, 7:    c = CMD_TICK;
        8:       c = ($urandom_range(3) == 0) ? CMD_START : CMD_TICK;
        default: c = 3'($urandom);
      endcase
      w = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(6));
      send_cmd(pack_cmd(c, 4'($urandom), ($urandom_range(1) ? 8'($urandom_range(3))
                                                             : 8'($urandom)), w));
      if (i == n / 2) drain();
    end
    drain();
  endtask

  initial begin
    model_reset();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 24; recv_idle_pct = 69;
    test_directed();
    test_random(400);
    send_idle_pct = 69; recv_idle_pct = 24;
    test_random(400);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(400);
    $display("sent %0d commands, checked %0d status items", sent, checked);
    $display("covered create, activate, terminate, wait, tick, start under stalls");
    if (errors == 0 && status_queue.size() == 0) begin
      $display("[priority_round_robin_scheduler] OK");
    end else begin
      $display("[priority_round_robin_scheduler] ERROR");
    end
    $finish;
  end

endmodule
